/* rtl/bpl_pkg.sv */
// Package for the bounded positional list.
// Sizes, operation and status codes, and the command/result structs.
// No dependencies.
`timescale 1ns / 1ps

package bpl_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 5;
  localparam int LEN_W      = 5;
  localparam int WORD_W     = 32;
  localparam int ACT_W      = 3;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT     = 3'd0,
    ACT_REMOVE     = 3'd1,
    ACT_READ       = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_PUSH_TAIL  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [POS_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] val;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] read_value;
    logic [LEN_W-1:0]  length;
  } res_t;

endpackage

/* rtl/bounded_positional_list.sv */
// Top level of the bounded positional list: cell chain, control and result register.
// Depends on bpl_pkg, bpl_ctrl and bpl_cell.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY (16) words, entry 0 at the front. Each input
// beat is one operation (insert, remove, read, push front, push tail) and
// yields exactly one result beat with status, read word and new length. The
// entries sit in a row of cells; an insert or remove shifts every affected
// cell together, and a new beat is taken every cycle while the result
// register is empty or being drained. The result is registered and shown
// in the cycle after its beat. Out-of-range positions (checked first) return
// status 1, inserts or pushes into a full list status 2; the list stays as is.
module bounded_positional_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[2:0], position[7:3], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], read_value[33:2], length[38:34], 0
);
  import bpl_pkg::*;

  logic                  fire;
  cmd_t                  cmd;
  res_t                  res;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  res_t                  out_res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  bpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .action    (in_tdata[2:0]),
    .position  (in_tdata[7:3]),
    .value     (in_tdata[39:8]),
    .cell_data (cell_q),
    .cmd       (cmd),
    .res       (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end
    bpl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (POS_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.length, out_res_r.read_value, out_res_r.status};

endmodule

/* rtl/bpl_cell.sv */
// One storage cell of the list chain.
// Loads the new word, takes its left or right neighbor, or holds. Uses bpl_pkg.
`timescale 1ns / 1ps

module bpl_cell (
  input  logic                           clk,
  input  bpl_pkg::cmd_t                  cmd,
  input  logic [bpl_pkg::POS_W-1:0]      idx,
  input  logic [bpl_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [bpl_pkg::DATA_WIDTH-1:0] right_data,
  output logic [bpl_pkg::DATA_WIDTH-1:0] data
);
  import bpl_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    priority if (cmd.ins && (idx == cmd.pos)) begin
      data_nxt = cmd.val;
    end else if (cmd.ins && (idx > cmd.pos)) begin
      data_nxt = left_data;
    end else if (cmd.del && (idx >= cmd.pos)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* rtl/bpl_ctrl.sv */
// Operation decode, range/full checks, entry count and read select.
// Drives the command broadcast to the cell chain. Uses bpl_pkg.
`timescale 1ns / 1ps

module bpl_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [bpl_pkg::ACT_W-1:0]      action,
  input  logic [bpl_pkg::POS_W-1:0]      position,
  input  logic [bpl_pkg::WORD_W-1:0]     value,
  input  logic [bpl_pkg::DATA_WIDTH-1:0] cell_data [bpl_pkg::CAPACITY],
  output bpl_pkg::cmd_t                  cmd,
  output bpl_pkg::res_t                  res
);
  import bpl_pkg::*;

  logic [LEN_W-1:0]      count_r;
  logic [LEN_W-1:0]      count_nxt;
  logic                  full;
  logic                  put;
  logic [POS_W-1:0]      put_pos;
  logic                  take;
  logic                  rd;
  status_t               status;
  logic [DATA_WIDTH-1:0] rd_word;

  assign full = (count_r == LEN_W'(CAPACITY));

  always_comb begin
    put     = 1'b0;
    put_pos = position;
    take    = 1'b0;
    rd      = 1'b0;
    status  = ST_RANGE;
    unique case (action)
      ACT_INSERT, ACT_PUSH_FRONT, ACT_PUSH_TAIL: begin
        if (action == ACT_PUSH_FRONT) begin
          put_pos = '0;
        end else if (action == ACT_PUSH_TAIL) begin
          put_pos = POS_W'(count_r);
        end
        if (put_pos > POS_W'(count_r)) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status = ST_DONE;
          put    = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (position < POS_W'(count_r)) begin
          status = ST_DONE;
          take   = 1'b1;
        end
      end
      ACT_READ: begin
        if (position < POS_W'(count_r)) begin
          status = ST_DONE;
          rd     = 1'b1;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  assign rd_word = rd ? cell_data[position[IDX_W-1:0]] : '0;

  always_comb begin
    count_nxt = count_r;
    if (fire && put) begin
      count_nxt = count_r + LEN_W'(1);
    end else if (fire && take) begin
      count_nxt = count_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign cmd.ins = fire && put;
  assign cmd.del = fire && take;
  assign cmd.pos = put ? put_pos : position;
  assign cmd.val = value[DATA_WIDTH-1:0];

  assign res.status     = status;
  assign res.read_value = WORD_W'(rd_word);
  assign res.length     = count_nxt;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del))
    else $error("insert and remove in one beat");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + LEN_W'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status == ST_FULL) |-> full && !put)
    else $error("full status on a list that is not full");

endmodule
